FILE: design/bbmv_pkg.sv
// ----------------------------------------------------------------------------
// bbmv_pkg
// Types and constants shared by the box match voting block.
// ----------------------------------------------------------------------------
package bbmv_pkg;

  localparam int MAX_BOXES = 16;
  localparam int IDX_W     = 4;
  localparam int CNT_W     = 5;
  localparam int COORD_W   = 12;
  localparam int VOTE_W    = 16;
  localparam int PAIR_W    = 2 * IDX_W;
  localparam int PAIRS     = MAX_BOXES * MAX_BOXES;
  localparam int ADDR_W    = 3;

  localparam logic [VOTE_W-1:0] VOTE_MAX = {VOTE_W{1'b1}};

  localparam logic [1:0] MODE_LOAD_CUR  = 2'd0;
  localparam logic [1:0] MODE_LOAD_PREV = 2'd1;
  localparam logic [1:0] MODE_MATCH     = 2'd2;
  localparam logic [1:0] MODE_FINISH    = 2'd3;

  localparam logic REG_CUR_COUNT  = 1'b0;
  localparam logic REG_PREV_COUNT = 1'b1;

  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
  } box_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic              clr;
    logic [PAIR_W-1:0] addr;
    logic [VOTE_W-1:0] wdata;
  } vote_req_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_HIT, ST_VRD, ST_VWR, ST_FRD, ST_FCMP, ST_FB, ST_EMIT, ST_CLR
  } state_t;

  function automatic logic box_holds(box_t b, logic [COORD_W-1:0] px,
                                     logic [COORD_W-1:0] py);
    logic [COORD_W:0] xe;
    logic [COORD_W:0] ye;
    xe = {1'b0, b.left} + {1'b0, b.width};
    ye = {1'b0, b.top} + {1'b0, b.height};
    return (px >= b.left) && ({1'b0, px} < xe) && (py >= b.top) && ({1'b0, py} < ye);
  endfunction

endpackage

FILE: design/bbmv_if.sv
// ----------------------------------------------------------------------------
// bbmv_in_if / bbmv_out_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface bbmv_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  mode;
  logic [bbmv_pkg::IDX_W-1:0]   box_index;
  logic [bbmv_pkg::COORD_W-1:0] box_left;
  logic [bbmv_pkg::COORD_W-1:0] box_top;
  logic [bbmv_pkg::COORD_W-1:0] box_width;
  logic [bbmv_pkg::COORD_W-1:0] box_height;
  logic [bbmv_pkg::COORD_W-1:0] current_point_x;
  logic [bbmv_pkg::COORD_W-1:0] current_point_y;
  logic [bbmv_pkg::COORD_W-1:0] previous_point_x;
  logic [bbmv_pkg::COORD_W-1:0] previous_point_y;

  modport source(output valid, mode, box_index, box_left, box_top, box_width, box_height,
                 current_point_x, current_point_y, previous_point_x, previous_point_y,
                 input ready);
  modport sink(input valid, mode, box_index, box_left, box_top, box_width, box_height,
               current_point_x, current_point_y, previous_point_x, previous_point_y,
               output ready);
endinterface

interface bbmv_out_if;
  logic                       valid;
  logic                       ready;
  logic [bbmv_pkg::IDX_W-1:0]  previous_box;
  logic [bbmv_pkg::IDX_W-1:0]  matched_current_box;
  logic [bbmv_pkg::VOTE_W-1:0] vote_count;
  logic                       found;
  logic                       last;

  modport source(output valid, previous_box, matched_current_box, vote_count, found, last,
                 input ready);
  modport sink(input valid, previous_box, matched_current_box, vote_count, found, last,
               output ready);
endinterface

FILE: design/bbmv_vote_mem.sv
// ----------------------------------------------------------------------------
// bbmv_vote_mem
// Pair vote counter memory with per-entry valid bits; unwritten entries read 0.
// ----------------------------------------------------------------------------
module bbmv_vote_mem (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bbmv_pkg::vote_req_t          req,
  output logic [bbmv_pkg::VOTE_W-1:0]  rdata
);
  import bbmv_pkg::*;

  logic [VOTE_W-1:0] mem [PAIRS];
  logic [PAIRS-1:0]  vld_r;
  logic [VOTE_W-1:0] rd_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_r <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || req.clr) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.addr];
      end
    end
  end

  assign rdata = rd_vld_r ? rd_r : '0;

endmodule

FILE: design/bounding_box_match_vote_top.sv
// ----------------------------------------------------------------------------
// bounding_box_match_vote_top
// Keypoint voting between current and previous frame boxes.
// ----------------------------------------------------------------------------
//  channel  | direction | content
//  in_if    | in        | box loads, match points, finish command
//  out_if   | out       | one association word per previous box
//  psel...  | in        | APB box count registers
//
// A load stores its box when it is accepted. A match runs containment tests on
// all 16 box slots, then visits each of the 256 box pairs, with a vote read and
// a write back for a pair that holds both points. Finish reads each counter
// (count_cur x count_prev), then for each previous box scans all 16 current box
// slots and sends a result word that waits for out ready, then clears. The single
// vote memory port sets this serial order. Reset is synchronous; counters read as
// zero after reset and after every finish.
module bounding_box_match_vote_top (
  input  logic        clk,
  input  logic        rst_n,
  bbmv_in_if.sink     in_if,
  bbmv_out_if.source  out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [bbmv_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bbmv_pkg::*;

  state_t st_r, st_nxt;
  logic [CNT_W-1:0] ncur_r, nprev_r, nc, np;
  box_t cur_r [MAX_BOXES];
  box_t prev_r [MAX_BOXES];
  logic [COORD_W-1:0] cx_r, cy_r, qx_r, qy_r;
  logic [MAX_BOXES-1:0] chit_r, phit_r;
  logic [IDX_W-1:0] c_r, c_nxt, p_r, p_nxt;
  logic [IDX_W-1:0] pick_r [MAX_BOXES];
  logic [VOTE_W-1:0] pv_r [MAX_BOXES];
  logic [VOTE_W-1:0] best_r, best_nxt;
  logic [IDX_W-1:0] bidx_r, bidx_nxt;
  logic found_r, found_nxt;
  logic [VOTE_W-1:0] vote;
  vote_req_t req;
  logic in_acc, c_last, p_last, c_use, upd;

  assign nc = (ncur_r > CNT_W'(MAX_BOXES)) ? CNT_W'(MAX_BOXES) : ncur_r;
  assign np = (nprev_r > CNT_W'(MAX_BOXES)) ? CNT_W'(MAX_BOXES) : nprev_r;
  assign in_acc = in_if.valid && in_if.ready;
  assign c_last = ({1'b0, c_r} == nc - CNT_W'(1));
  assign p_last = ({1'b0, p_r} == np - CNT_W'(1));
  assign c_use  = ({1'b0, c_r} < nc);
  assign upd    = c_use && (pick_r[c_r] == p_r) && (!found_r || pv_r[c_r] > best_r);

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = {{(32-CNT_W){1'b0}}, (paddr[2] == REG_PREV_COUNT) ? nprev_r : ncur_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncur_r  <= '0;
      nprev_r <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_CUR_COUNT) begin
        ncur_r <= pwdata[CNT_W-1:0];
      end else begin
        nprev_r <= pwdata[CNT_W-1:0];
      end
    end
  end

  bbmv_vote_mem u_mem (.clk(clk), .rst_n(rst_n), .req(req), .rdata(vote));

  // Next state and loop indices.
  always_comb begin
    st_nxt    = st_r;
    c_nxt     = c_r;
    p_nxt     = p_r;
    best_nxt  = best_r;
    bidx_nxt  = bidx_r;
    found_nxt = found_r;
    case (st_r)
      ST_IDLE: begin
        c_nxt = '0;
        p_nxt = '0;
        found_nxt = 1'b0;
        if (in_acc && in_if.mode == MODE_MATCH) begin
          st_nxt = ST_HIT;
        end else if (in_acc && in_if.mode == MODE_FINISH) begin
          if (np == '0) st_nxt = ST_CLR;
          else if (nc == '0) st_nxt = ST_FB;
          else st_nxt = ST_FRD;
        end
      end
      ST_HIT: begin
        c_nxt = c_r + IDX_W'(1);
        if (c_r == IDX_W'(MAX_BOXES - 1)) begin
          c_nxt  = '0;
          st_nxt = ST_VRD;
        end
      end
      ST_VRD, ST_VWR: begin
        if (st_r == ST_VRD && chit_r[c_r] && phit_r[p_r]) begin
          st_nxt = ST_VWR;
        end else begin
          st_nxt = ST_VRD;
          {c_nxt, p_nxt} = {c_r, p_r} + PAIR_W'(1);
          if ({c_r, p_r} == PAIR_W'(PAIRS - 1)) st_nxt = ST_IDLE;
        end
      end
      ST_FRD: st_nxt = ST_FCMP;
      ST_FCMP: begin
        st_nxt = ST_FRD;
        if (p_r == '0 || vote > best_r) begin
          best_nxt = vote;
          bidx_nxt = p_r;
        end
        p_nxt = p_r + IDX_W'(1);
        if (p_last) begin
          p_nxt = '0;
          c_nxt = c_r + IDX_W'(1);
          if (c_last) begin
            c_nxt  = '0;
            st_nxt = ST_FB;
          end
        end
      end
      ST_FB: begin
        if (upd) begin
          found_nxt = 1'b1;
          best_nxt  = pv_r[c_r];
          bidx_nxt  = c_r;
        end
        c_nxt = c_r + IDX_W'(1);
        if (c_r == IDX_W'(MAX_BOXES - 1)) st_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_if.ready) begin
          found_nxt = 1'b0;
          c_nxt = '0;
          p_nxt = p_r + IDX_W'(1);
          st_nxt = p_last ? ST_CLR : ST_FB;
        end
      end
      ST_CLR: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Outputs and memory control.
  always_comb begin
    in_if.ready = (st_r == ST_IDLE);
    out_if.valid = (st_r == ST_EMIT);
    out_if.previous_box = p_r;
    out_if.matched_current_box = found_r ? bidx_r : '0;
    out_if.vote_count = found_r ? best_r : '0;
    out_if.found = found_r;
    out_if.last = p_last;
    req.rd_en = 1'b0;
    req.wr_en = 1'b0;
    req.clr   = 1'b0;
    req.addr  = {c_r, p_r};
    req.wdata = (vote == VOTE_MAX) ? vote : vote + VOTE_W'(1);
    case (st_r)
      ST_VRD:  req.rd_en = chit_r[c_r] && phit_r[p_r];
      ST_VWR:  req.wr_en = 1'b1;
      ST_FRD:  req.rd_en = 1'b1;
      ST_CLR:  req.clr   = 1'b1;
      default: req.rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      c_r     <= '0;
      p_r     <= '0;
      found_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      c_r     <= c_nxt;
      p_r     <= p_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
    bidx_r <= bidx_nxt;
    if (in_acc && in_if.mode == MODE_LOAD_CUR) begin
      cur_r[in_if.box_index] <= '{in_if.box_left, in_if.box_top, in_if.box_width,
                                   in_if.box_height};
    end
    if (in_acc && in_if.mode == MODE_LOAD_PREV) begin
      prev_r[in_if.box_index] <= '{in_if.box_left, in_if.box_top, in_if.box_width,
                                    in_if.box_height};
    end
    if (in_acc) begin
      cx_r <= in_if.current_point_x;
      cy_r <= in_if.current_point_y;
      qx_r <= in_if.previous_point_x;
      qy_r <= in_if.previous_point_y;
    end
    if (st_r == ST_HIT) begin
      chit_r[c_r] <= c_use && box_holds(cur_r[c_r], cx_r, cy_r);
      phit_r[c_r] <= ({1'b0, c_r} < np) && box_holds(prev_r[c_r], qx_r, qy_r);
    end
    // The last counter of a row settles the pick of that current box.
    if (st_r == ST_FCMP && p_last) begin
      pick_r[c_r] <= (p_r == '0 || vote > best_r) ? p_r : bidx_r;
      pv_r[c_r]   <= (p_r == '0 || vote > best_r) ? vote : best_r;
    end
  end

`ifndef SYNTH
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> !in_if.ready) else $error("input taken while a word is pending");
  a_match_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_if.mode == MODE_MATCH) |=> st_r == ST_HIT)
    else $error("match word did not start the hit scan");
  a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_CLR |=> st_r == ST_IDLE) else $error("clear did not return to idle");
  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.found) |-> (out_if.vote_count == '0 &&
    out_if.matched_current_box == '0)) else $error("unmatched word carries data");
`endif

endmodule

FILE: verif/bbmv_checker.sv
// ----------------------------------------------------------------------------
// bbmv_checker
// Watches the box load, match and finish words going into the voting block
// and the association words coming out of it. It keeps its own copy of the
// boxes, the box counts and the vote table, and predicts one association
// word per previous box on each finish. Those words are compared, all fields
// at once and in order, with what the block sends.
// ----------------------------------------------------------------------------
module bbmv_checker
  import bbmv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  bbmv_in_if                in_mon,
  bbmv_out_if               out_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output int                errors,
  output int                pending
);

  typedef struct packed {
    logic [IDX_W-1:0]  prev_box;
    logic [IDX_W-1:0]  cur_box;
    logic [VOTE_W-1:0] votes;
    logic              found;
    logic              last;
  } assoc_t;

  assoc_t            assoc_q[$];
  box_t              cur_boxes[MAX_BOXES];
  box_t              prev_boxes[MAX_BOXES];
  logic [VOTE_W-1:0] pair_tally[MAX_BOXES][MAX_BOXES];
  logic [CNT_W-1:0]  cur_count;
  logic [CNT_W-1:0]  prev_count;

  // Half-open test; the sums are taken at 32 bits so that a box reaching
  // past the last pixel column still ends where it should.
  function automatic bit covers(box_t b, logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
    int unsigned x_end;
    int unsigned y_end;
    x_end = int'(b.left) + int'(b.width);
    y_end = int'(b.top) + int'(b.height);
    return px >= b.left && int'(px) < x_end && py >= b.top && int'(py) < y_end;
  endfunction

  function automatic int in_use(logic [CNT_W-1:0] n);
    return (n > MAX_BOXES) ? MAX_BOXES : int'(n);
  endfunction

  task automatic tally_match(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                             logic [COORD_W-1:0] qx, logic [COORD_W-1:0] qy);
    int nc;
    int np;
    nc = in_use(cur_count);
    np = in_use(prev_count);
    for (int c = 0; c < nc; c++) begin
      if (covers(cur_boxes[c], cx, cy)) begin
        for (int p = 0; p < np; p++) begin
          if (covers(prev_boxes[p], qx, qy) && pair_tally[c][p] != VOTE_MAX)
            pair_tally[c][p] = pair_tally[c][p] + 1'b1;
        end
      end
    end
  endtask

  task automatic predict_associations();
    int          nc;
    int          np;
    int          pick[MAX_BOXES];
    int unsigned pick_votes[MAX_BOXES];
    assoc_t      a;
    nc = in_use(cur_count);
    np = in_use(prev_count);
    for (int c = 0; c < nc; c++) begin
      pick[c] = -1;
      pick_votes[c] = 0;
      for (int p = 0; p < np; p++) begin
        if (pick[c] < 0 || pair_tally[c][p] > pick_votes[c]) begin
          pick[c] = p;
          pick_votes[c] = pair_tally[c][p];
        end
      end
    end
    for (int p = 0; p < np; p++) begin
      a = '0;
      a.prev_box = p[IDX_W-1:0];
      for (int c = 0; c < nc; c++) begin
        if (pick[c] == p && (!a.found || pick_votes[c] > a.votes)) begin
          a.found = 1'b1;
          a.cur_box = c[IDX_W-1:0];
          a.votes = pick_votes[c][VOTE_W-1:0];
        end
      end
      a.last = (p + 1 == np);
      assoc_q = {assoc_q, a};
    end
    for (int c = 0; c < MAX_BOXES; c++)
      for (int p = 0; p < MAX_BOXES; p++)
        pair_tally[c][p] = '0;
  endtask

  always @(posedge clk) begin
    assoc_t got;
    assoc_t want;
    if (!rst_n) begin
      errors = 0;
      assoc_q.delete();
      cur_count = '0;
      prev_count = '0;
      for (int c = 0; c < MAX_BOXES; c++)
        for (int p = 0; p < MAX_BOXES; p++)
          pair_tally[c][p] = '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_CUR_COUNT)
          cur_count = pwdata[CNT_W-1:0];
        else
          prev_count = pwdata[CNT_W-1:0];
      end
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.mode)
          MODE_LOAD_CUR: begin
            cur_boxes[in_mon.box_index] = '{in_mon.box_left, in_mon.box_top,
                                            in_mon.box_width, in_mon.box_height};
          end
          MODE_LOAD_PREV: begin
            prev_boxes[in_mon.box_index] = '{in_mon.box_left, in_mon.box_top,
                                             in_mon.box_width, in_mon.box_height};
          end
          MODE_MATCH: begin
            tally_match(in_mon.current_point_x, in_mon.current_point_y,
                        in_mon.previous_point_x, in_mon.previous_point_y);
          end
          default: predict_associations();
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.previous_box, out_mon.matched_current_box, out_mon.vote_count,
                out_mon.found, out_mon.last};
        if (assoc_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word: prev=%0d cur=%0d votes=%0d found=%0d last=%0d",
                   $time, got.prev_box, got.cur_box, got.votes, got.found, got.last);
        end else begin
          want = assoc_q.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: result mismatch: expected prev=%0d cur=%0d votes=%0d found=%0d last=%0d",
                     $time, want.prev_box, want.cur_box, want.votes, want.found, want.last);
            $display("%0t:                  actual   prev=%0d cur=%0d votes=%0d found=%0d last=%0d",
                     $time, got.prev_box, got.cur_box, got.votes, got.found, got.last);
          end
        end
      end
    end
    pending = assoc_q.size();
  end

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the box match voting block.
// Loads boxes at the extremes, votes with points on and around box edges,
// then runs phases of random box counts, box reloads and mostly aimed match
// words, each phase closed by a finish. The sender bursts, the receiver
// stalls on its own pattern, and the checker beside the block predicts and
// compares every result word.
// ----------------------------------------------------------------------------
module tb;
  import bbmv_pkg::*;

  typedef struct {
    logic [1:0]         mode;
    logic [IDX_W-1:0]   idx;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] qx;
    logic [COORD_W-1:0] qy;
  } word_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  int                errors;
  int                pending;

  bbmv_in_if  in_if ();
  bbmv_out_if out_if ();

  bounding_box_match_vote_top dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  bbmv_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_if), .out_mon(out_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
  );

  box_t cur_copy[MAX_BOXES];
  box_t prev_copy[MAX_BOXES];
  int   words_sent;
  int   burst_left;
  int   hold_seq;

  initial begin
    clk = 1'b0;
  end

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #(20 * 3000000);
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: a long hold-off on request, otherwise stretches of always
  // ready, coin-flip ready and mostly stalled.
  initial begin
    int style;
    int style_left;
    int hold_left;
    int seen_seq;
    out_if.ready = 1'b0;
    style_left = 0;
    hold_left = 0;
    seen_seq = 0;
    style = 0;
    forever begin
      @(negedge clk);
      if (hold_seq != seen_seq) begin
        seen_seq = hold_seq;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready = 1'b0;
      end else begin
        if (style_left == 0) begin
          style = $urandom_range(0, 2);
          style_left = $urandom_range(20, 200);
        end
        style_left--;
        case (style)
          0: out_if.ready = 1'b1;
          1: out_if.ready = ($urandom_range(0, 1) == 1);
          default: out_if.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic reg_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_counts(int nc, int np);
    reg_write({REG_CUR_COUNT, 2'b00}, nc);
    reg_write({REG_PREV_COUNT, 2'b00}, np);
  endtask

  task automatic send_word(word_t w);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_if.valid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
    in_if.mode = w.mode;
    in_if.box_index = w.idx;
    in_if.box_left = w.left;
    in_if.box_top = w.top;
    in_if.box_width = w.width;
    in_if.box_height = w.height;
    in_if.current_point_x = w.cx;
    in_if.current_point_y = w.cy;
    in_if.previous_point_x = w.qx;
    in_if.previous_point_y = w.qy;
    in_if.valid = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    words_sent++;
  endtask

  function automatic word_t noise_word(logic [1:0] mode);
    word_t w;
    w.mode = mode;
    w.idx = IDX_W'($urandom);
    w.left = COORD_W'($urandom);
    w.top = COORD_W'($urandom);
    w.width = COORD_W'($urandom);
    w.height = COORD_W'($urandom);
    w.cx = COORD_W'($urandom);
    w.cy = COORD_W'($urandom);
    w.qx = COORD_W'($urandom);
    w.qy = COORD_W'($urandom);
    return w;
  endfunction

  task automatic load_box(logic [1:0] mode, int slot, int l, int t, int wd, int ht);
    word_t w;
    w = noise_word(mode);
    w.idx = IDX_W'(slot);
    w.left = COORD_W'(l);
    w.top = COORD_W'(t);
    w.width = COORD_W'(wd);
    w.height = COORD_W'(ht);
    if (mode == MODE_LOAD_CUR)
      cur_copy[slot] = '{w.left, w.top, w.width, w.height};
    else
      prev_copy[slot] = '{w.left, w.top, w.width, w.height};
    send_word(w);
  endtask

  task automatic load_random_box(logic [1:0] mode, int slot);
    if ($urandom_range(0, 3) == 0)
      load_box(mode, slot, $urandom, $urandom, $urandom, $urandom);
    else
      load_box(mode, slot, $urandom_range(0, 3800), $urandom_range(0, 3800),
               $urandom_range(0, 300), $urandom_range(0, 300));
  endtask

  task automatic match_at(int cx, int cy, int qx, int qy);
    word_t w;
    w = noise_word(MODE_MATCH);
    w.cx = COORD_W'(cx);
    w.cy = COORD_W'(cy);
    w.qx = COORD_W'(qx);
    w.qy = COORD_W'(qy);
    send_word(w);
  endtask

  function automatic int spot(logic [COORD_W-1:0] base, logic [COORD_W-1:0] span);
    if (span == 0)
      return $urandom_range(0, 4095);
    return (int'(base) + $urandom_range(0, int'(span) - 1)) % 4096;
  endfunction

  // Most match words land inside a chosen box pair; some are pure noise.
  task automatic aimed_match();
    box_t bc;
    box_t bp;
    bc = cur_copy[$urandom_range(0, MAX_BOXES - 1)];
    bp = prev_copy[$urandom_range(0, MAX_BOXES - 1)];
    if ($urandom_range(0, 3) == 0)
      send_word(noise_word(MODE_MATCH));
    else
      match_at(spot(bc.left, bc.width), spot(bc.top, bc.height),
               spot(bp.left, bp.width), spot(bp.top, bp.height));
  endtask

  task automatic finish_frame();
    send_word(noise_word(MODE_FINISH));
  endtask

  // A match word can still be in flight when nothing is expected, so
  // the wait covers a full pass over the vote table.
  task automatic drain();
    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (1200) @(negedge clk);
  endtask

  initial begin
    int nc;
    int np;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.mode = MODE_LOAD_CUR;
    in_if.box_index = '0;
    in_if.box_left = '0;
    in_if.box_top = '0;
    in_if.box_width = '0;
    in_if.box_height = '0;
    in_if.current_point_x = '0;
    in_if.current_point_y = '0;
    in_if.previous_point_x = '0;
    in_if.previous_point_y = '0;
    words_sent = 0;
    burst_left = 0;
    hold_seq = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Every slot is loaded before any match word lets the block read it.
    set_counts(16, 16);
    load_box(MODE_LOAD_CUR, 0, 0, 0, 4095, 4095);
    load_box(MODE_LOAD_CUR, 1, 4095, 4095, 4095, 4095);
    load_box(MODE_LOAD_CUR, 2, 100, 100, 0, 50);
    load_box(MODE_LOAD_CUR, 3, 100, 100, 50, 0);
    load_box(MODE_LOAD_CUR, 4, 10, 10, 5, 5);
    load_box(MODE_LOAD_PREV, 0, 0, 0, 1, 1);
    load_box(MODE_LOAD_PREV, 1, 4095, 4095, 1, 1);
    load_box(MODE_LOAD_PREV, 15, 10, 10, 5, 5);
    for (int s = 5; s < MAX_BOXES; s++)
      load_random_box(MODE_LOAD_CUR, s);
    for (int s = 2; s < MAX_BOXES - 1; s++)
      load_random_box(MODE_LOAD_PREV, s);
    match_at(0, 0, 0, 0);
    match_at(4095, 4095, 4095, 4095);
    match_at(100, 120, 120, 100);
    match_at(15, 12, 15, 12);
    match_at(14, 14, 14, 14);
    match_at(10, 15, 10, 10);
    finish_frame();
    drain();
    set_counts(0, 5);
    match_at(0, 0, 0, 0);
    finish_frame();
    drain();
    set_counts(5, 0);
    match_at(0, 0, 0, 0);
    finish_frame();
    drain();
    set_counts(31, 17);
    match_at(12, 12, 12, 12);
    finish_frame();
    drain();

    // Phases of random counts, reloads and match words, each ended by a finish.
    for (int phase = 0; words_sent < 260; phase++) begin
      case ($urandom_range(0, 5))
        0: begin nc = 16; np = 16; end
        1: begin nc = $urandom_range(0, 31); np = $urandom_range(0, 31); end
        2: begin nc = 1; np = $urandom_range(1, 16); end
        default: begin nc = $urandom_range(1, 16); np = $urandom_range(1, 16); end
      endcase
      // The hold-off phase needs a full set of result words to back up the block.
      if (phase == 2) begin
        nc = 16;
        np = 16;
      end
      set_counts(nc, np);
      repeat ($urandom_range(0, 4))
        load_random_box(2'($urandom_range(0, 1)), $urandom_range(0, MAX_BOXES - 1));
      if (phase == 2) begin
        // The receiver holds off while a finish is pending, and the sender keeps going.
        hold_seq++;
        repeat (3) aimed_match();
        finish_frame();
        repeat (8) aimed_match();
        finish_frame();
      end else begin
        repeat ($urandom_range(3, 20)) aimed_match();
        if ($urandom_range(0, 5) == 0)
          send_word(noise_word(2'($urandom_range(0, 3))));
        finish_frame();
      end
      drain();
    end

    drain();
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
design/bbmv_pkg.sv
design/bbmv_if.sv
design/bbmv_vote_mem.sv
design/bounding_box_match_vote_top.sv
verif/bbmv_checker.sv
verif/tb.sv
